[hdl/msfd_pkg.sv]
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared types and constants of the multi-server fifo dispatcher.
// ----------------------------------------------------------------------------
package msfd_pkg;

  // fixed field widths of the ports
  localparam int CFG_W  = 5;
  localparam int SVC_W  = 16;
  localparam int CNT_OW = 5;
  localparam int WAIT_W = 7;

  // item modes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // control from the sequencer to the head unit
  typedef struct packed {
    logic clear;    // new item, reset the scan accumulators
    logic active;   // a server countdown sits at the head this cycle
    logic is_tick;  // item is a tick
    logic enabled;  // server at the head is among the enabled ones
  } scan_ctl_t;

  // events from the head unit back to the sequencer
  typedef struct packed {
    logic place;    // arriving job taken by the server at the head
    logic pop;      // waiting job handed to the server at the head
  } head_ev_t;

endpackage

[hdl/multi_server_fifo_dispatcher.sv]
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher
// Bank of countdown servers sharing one waiting fifo of job service times.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. mode_i selects a
//   job arrival (service_time_i is its length) or one time tick.
//   The server countdowns sit in a ring of cells that rotates one place per
//   cycle while an item is scanned, past a single head unit, which places
//   the arriving job, hands waiting jobs to free servers in fifo order,
//   counts down and tallies the free and busy counts. Each item passes
//   through the scan state, which turns the ring once, and then the finish
//   state; busy stays high for that time. The result (free, busy, waiting
//   counts and the drop flag) shows on the result ports for one cycle with
//   result_valid_o high, in the first cycle with busy low, registered from
//   the finish state. The next item can be taken at the end of that cycle;
//   no item is taken before the result of the last one shows.
//   The receiver cannot stall; every result is a transfer.
//   The server count register is written through cfg_valid_i/cfg_ready_o
//   while the block is idle; it reads as 1 after reset.
//   Reset empties the fifo and frees every server; fifo storage itself is
//   not cleared, only entries written by arrivals are ever read.
// ----------------------------------------------------------------------------
module multi_server_fifo_dispatcher #(
  parameter int MAX_SERVERS = 16,
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic [msfd_pkg::SVC_W-1:0]    service_time_i,
  output logic                          result_valid_o,
  output logic [msfd_pkg::CNT_OW-1:0]   free_servers_o,
  output logic [msfd_pkg::CNT_OW-1:0]   busy_servers_o,
  output logic [msfd_pkg::WAIT_W-1:0]   waiting_jobs_o,
  output logic                          dropped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [msfd_pkg::CFG_W-1:0]    cfg_data_i
);

  import msfd_pkg::*;

  localparam int IW    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam logic [32:0] TMAX = (33'd1 << TIME_WIDTH) - 33'd1;

  state_e state_q, state_d;

  logic [CFG_W-1:0]      cfg_q;
  logic [CW-1:0]         cfg_ext;
  logic [CW-1:0]         n_eff;

  logic                  accept;
  logic                  mode_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic [32:0]           t_wide;
  logic [TIME_WIDTH-1:0] t_clamped;

  logic [IW-1:0]         idx_q, idx_d;
  logic                  idx_last;

  logic [TIME_WIDTH-1:0] ring_q [MAX_SERVERS];
  logic [TIME_WIDTH-1:0] new_time;
  logic                  shift;

  scan_ctl_t             ctl;
  head_ev_t              ev;
  logic [CNT_W-1:0]      busy_cnt;
  logic [CNT_W-1:0]      free_cnt;
  logic                  placed;

  logic [TIME_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] rd_q;
  logic [HW-1:0]         head_q, head_d, head_next;
  logic [FW-1:0]         fill_q, fill_d, fill_after;
  logic [HW-1:0]         rd_addr;
  logic [HW-1:0]         wr_addr;
  logic [SW-1:0]         wr_sum;
  logic                  push;
  logic                  drop;
  logic                  finish;

  // ---------------------------------------------------------------- config
  // the server count must not change while an item is being scanned
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    cfg_ext = CW'(cfg_q);
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > CW'(MAX_SERVERS)) begin
      n_eff = CW'(MAX_SERVERS);
    end else begin
      n_eff = cfg_ext;
    end
  end

  // ---------------------------------------------------------------- item
  assign accept = start && !busy;

  always_comb begin
    t_wide = 33'(service_time_i);
    if (t_wide == '0) begin
      t_clamped = TIME_WIDTH'(1);
    end else if (t_wide > TMAX) begin
      t_clamped = TMAX[TIME_WIDTH-1:0];
    end else begin
      t_clamped = t_wide[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      time_q <= t_clamped;
    end
  end

  // ---------------------------------------------------------------- fsm
  assign idx_last = (idx_q == IW'(MAX_SERVERS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    shift   = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        idx_d = idx_q + IW'(1);
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // ---------------------------------------------------------------- ring
  // the ring turns once per item, so server idx_q sits at the head
  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    logic [TIME_WIDTH-1:0] d_in;
    if (i == MAX_SERVERS - 1) begin : g_tail
      assign d_in = new_time;
    end else begin : g_mid
      assign d_in = ring_q[i+1];
    end
    msfd_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (d_in),
      .q_o     (ring_q[i])
    );
  end

  always_comb begin
    ctl.clear   = accept;
    ctl.active  = shift;
    ctl.is_tick = (mode_q == MODE_TICK);
    ctl.enabled = (CW'(idx_q) < n_eff);
  end

  msfd_head #(
    .TIME_WIDTH (TIME_WIDTH),
    .CNT_W      (CNT_W)
  ) u_head (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .arr_time_i   (time_q),
    .cur_time_i   (ring_q[0]),
    .fifo_data_i  (rd_q),
    .fifo_avail_i (fill_q != '0),
    .new_time_o   (new_time),
    .ev_o         (ev),
    .busy_cnt_o   (busy_cnt),
    .free_cnt_o   (free_cnt),
    .placed_o     (placed)
  );

  // ---------------------------------------------------------------- fifo
  assign head_next = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
  // read ahead so the next head entry is ready in the cycle after a pop
  assign rd_addr   = ev.pop ? head_next : head_q;

  always_comb begin
    wr_sum = SW'(head_q) + SW'(fill_q);
    if (wr_sum >= SW'(QUEUE_DEPTH)) begin
      wr_addr = HW'(wr_sum - SW'(QUEUE_DEPTH));
    end else begin
      wr_addr = HW'(wr_sum);
    end
  end

  always_comb begin
    push = finish && (mode_q == MODE_ARRIVAL) && !placed
           && (fill_q != FW'(QUEUE_DEPTH));
    drop = finish && (mode_q == MODE_ARRIVAL) && !placed
           && (fill_q == FW'(QUEUE_DEPTH));
    fill_after = push ? fill_q + FW'(1) : fill_q;

    head_d = head_q;
    fill_d = fill_after;
    if (ev.pop) begin
      head_d = head_next;
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_addr] <= time_q;
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      free_servers_o <= CNT_OW'(free_cnt);
      busy_servers_o <= CNT_OW'(busy_cnt);
      waiting_jobs_o <= WAIT_W'(fill_after);
      dropped_o      <= drop;
    end
  end

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(QUEUE_DEPTH))
    else $error("fifo fill beyond depth");

  a_pop_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.pop |-> (mode_q == MODE_TICK) && (fill_q != '0))
    else $error("fifo pop outside a tick or from an empty fifo");

  a_place_on_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.place |-> (mode_q == MODE_ARRIVAL) && !placed && (ring_q[0] == '0))
    else $error("arrival placed twice or on a busy server");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> result_valid_o && !busy)
    else $error("finish without a result strobe");

  a_no_push_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && drop) && !(push && ev.pop))
    else $error("conflicting fifo operations");

endmodule

[hdl/msfd_cell.sv]
// ----------------------------------------------------------------------------
// msfd_cell
// One server countdown register in the rotating ring.
// ----------------------------------------------------------------------------
module msfd_cell #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [TIME_WIDTH-1:0] d_i,
  output logic [TIME_WIDTH-1:0] q_o
);

  logic [TIME_WIDTH-1:0] time_q;
  logic [TIME_WIDTH-1:0] time_d;

  always_comb begin
    time_d = shift_i ? d_i : time_q;
  end

  // zero means the server is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else begin
      time_q <= time_d;
    end
  end

  assign q_o = time_q;

endmodule

[hdl/msfd_head.sv]
// ----------------------------------------------------------------------------
// msfd_head
// Processing point of the ring: assigns jobs, counts down, tallies counts.
// ----------------------------------------------------------------------------
module msfd_head #(
  parameter int TIME_WIDTH = 16,
  parameter int CNT_W      = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msfd_pkg::scan_ctl_t           ctl_i,
  input  logic [TIME_WIDTH-1:0]         arr_time_i,
  input  logic [TIME_WIDTH-1:0]         cur_time_i,
  input  logic [TIME_WIDTH-1:0]         fifo_data_i,
  input  logic                          fifo_avail_i,
  output logic [TIME_WIDTH-1:0]         new_time_o,
  output msfd_pkg::head_ev_t            ev_o,
  output logic [CNT_W-1:0]              busy_cnt_o,
  output logic [CNT_W-1:0]              free_cnt_o,
  output logic                          placed_o
);

  import msfd_pkg::*;

  logic                  free_here;
  logic [TIME_WIDTH-1:0] src_time;
  logic                  placed_q, placed_d;
  logic [CNT_W-1:0]      busy_q, busy_d;
  logic [CNT_W-1:0]      free_q, free_d;

  always_comb begin
    free_here   = (cur_time_i == '0) && ctl_i.enabled;
    ev_o.place  = ctl_i.active && !ctl_i.is_tick && free_here && !placed_q;
    ev_o.pop    = ctl_i.active && ctl_i.is_tick && free_here && fifo_avail_i;

    if (ctl_i.is_tick) begin
      // a job handed over on a tick already loses this tick
      src_time   = ev_o.pop ? fifo_data_i : cur_time_i;
      new_time_o = (src_time != '0) ? src_time - TIME_WIDTH'(1) : '0;
    end else begin
      src_time   = cur_time_i;
      new_time_o = ev_o.place ? arr_time_i : cur_time_i;
    end

    placed_d = placed_q;
    busy_d   = busy_q;
    free_d   = free_q;
    if (ctl_i.clear) begin
      placed_d = 1'b0;
      busy_d   = '0;
      free_d   = '0;
    end else if (ctl_i.active) begin
      if (ev_o.place) begin
        placed_d = 1'b1;
      end
      if (new_time_o != '0) begin
        busy_d = busy_q + CNT_W'(1);
      end else if (ctl_i.enabled) begin
        free_d = free_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
      busy_q   <= '0;
      free_q   <= '0;
    end else begin
      placed_q <= placed_d;
      busy_q   <= busy_d;
      free_q   <= free_d;
    end
  end

  assign busy_cnt_o = busy_q;
  assign free_cnt_o = free_q;
  assign placed_o   = placed_q;

endmodule
